// ===== hdl/bpa_pkg.sv =====
`default_nettype none
package bpa_pkg;

   // Fixed field widths of the request and response channels.
   localparam int ACTION_W = 1;
   localparam int COUNT_W  = 7;
   localparam int BLK_ID_W = 16;
   localparam int STATUS_W = 3;
   localparam int GRANT_ID_W = 10;
   localparam int COUNT_OUT_W = 11;

   // Largest number of blocks one allocate request may take.
   localparam logic [COUNT_W-1:0] MAX_GRANT = 7'd64;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_OOM       = 3'd1,
      STATUS_RANGE     = 3'd2,
      STATUS_DOUBLE    = 3'd3,
      STATUS_NONE      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALLOC_CHK,
      ST_ALLOC_RUN,
      ST_FREE_CHK
   } state_type;

endpackage
`default_nettype wire

// ===== hdl/bpa_if.sv =====
`default_nettype none
interface bpa_req_if;
   logic                                valid;
   logic                                ready;
   logic [bpa_pkg::ACTION_W-1:0]        action;
   logic [bpa_pkg::COUNT_W-1:0]         count;
   logic signed [bpa_pkg::BLK_ID_W-1:0] blk_id;

   modport source (output valid, output action, output count, output blk_id,
                   input ready);
   modport sink (input valid, input action, input count, input blk_id,
                 output ready);
endinterface

interface bpa_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [bpa_pkg::STATUS_W-1:0]         status;
   logic [bpa_pkg::GRANT_ID_W-1:0]       granted_id;
   logic                                 last;
   logic [bpa_pkg::COUNT_OUT_W-1:0]      free_count;
   logic [bpa_pkg::COUNT_OUT_W-1:0]      used_count;

   modport source (output valid, output status, output granted_id, output last,
                   output free_count, output used_count, input ready);
   modport sink (input valid, input status, input granted_id, input last,
                 input free_count, input used_count, output ready);
endinterface
`default_nettype wire

// ===== hdl/bpa_stack.sv =====
`default_nettype none
module bpa_stack #(
   parameter int POOL_SIZE = 1024,
   parameter int IDW = 10,
   parameter int DW = 11
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           pop,
   input  logic           push,
   input  logic [IDW-1:0] push_id,
   output logic [DW-1:0]  depth,
   output logic [DW-1:0]  low_mark,
   output logic [IDW-1:0] pop_id
);

   logic [IDW-1:0] mem [POOL_SIZE];
   logic [IDW-1:0] rd_data_ff;
   logic [IDW-1:0] rd_addr_ff;
   logic           fresh_ff;
   logic [DW-1:0]  depth_ff, depth_in;
   logic [DW-1:0]  mark_ff, mark_in;
   logic [DW-1:0]  top_index;

   assign top_index = depth_ff - DW'(1);

   // Entries below the lowest depth seen since reset were never written; a
   // pop from one of them returns an id derived from its index.
   always_comb begin
      depth_in = depth_ff;
      mark_in  = mark_ff;
      if (pop) begin
         depth_in = top_index;
         if (depth_ff == mark_ff) begin
            mark_in = top_index;
         end
      end else if (push) begin
         depth_in = depth_ff + DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DW'(POOL_SIZE);
         mark_ff  <= DW'(POOL_SIZE);
      end else begin
         depth_ff <= depth_in;
         mark_ff  <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[depth_ff[IDW-1:0]] <= push_id;
      end
      if (pop) begin
         rd_data_ff <= mem[top_index[IDW-1:0]];
         rd_addr_ff <= top_index[IDW-1:0];
         fresh_ff   <= (depth_ff == mark_ff);
      end
   end

   assign pop_id   = fresh_ff ? (IDW'(POOL_SIZE - 1) - rd_addr_ff) : rd_data_ff;
   assign depth    = depth_ff;
   assign low_mark = mark_ff;

endmodule
`default_nettype wire

// ===== hdl/bpa_busy.sv =====
`default_nettype none
module bpa_busy #(
   parameter int POOL_SIZE = 1024,
   parameter int IDW = 10,
   parameter int DW = 11
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [IDW-1:0] wr_addr,
   input  logic           wr_bit,
   input  logic           rd_en,
   input  logic [IDW-1:0] rd_addr,
   input  logic [DW-1:0]  low_mark,
   output logic           busy
);

   logic           mem [POOL_SIZE];
   logic           rd_data_ff;
   logic           touched_ff;
   logic [DW:0]    reach;

   // Ids below POOL_SIZE - low_mark were handed out at least once, so their
   // entries have been written; all others read as free.
   assign reach = (DW+1)'(rd_addr) + (DW+1)'(low_mark);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_bit;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         touched_ff <= (reach < (DW+1)'(POOL_SIZE));
      end
   end

   assign busy = touched_ff & rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/block_pool_allocator.sv =====
`default_nettype none
// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+------------------------------------------
// req_port | in  | valid/ready, sink      | action, count, blk_id (signed)
// rsp_port | out | valid/ready, source    | status, granted_id, last, free_count,
//          |     |                        | used_count
//
// A request is checked in the cycle after it is taken. An allocate of n
// blocks gives its n responses one per cycle when no response stall holds
// them. The pop rate is set by the single read port of the free stack
// memory, whose read data arrives in the cycle after the pop. Reset clears
// the control state at once; neither memory needs a clearing pass. Response
// stalls hold the pop pipeline in place without losing data.
module block_pool_allocator #(
   parameter int POOL_SIZE = 1024
) (
   input  logic       clock,
   input  logic       reset,
   bpa_req_if.sink    req_port,
   bpa_rsp_if.source  rsp_port
);

   localparam int IDW  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int DW   = $clog2(POOL_SIZE + 1);
   localparam int CMPW = DW + 8;

   bpa_pkg::state_type  state_ff, state_in;

   // Latched request.
   logic [bpa_pkg::COUNT_W-1:0] count_ff;
   logic [IDW-1:0]              id_ff;
   logic                        range_bad_ff, range_bad_in;

   // Blocks still to hand out in the current grant.
   logic [bpa_pkg::COUNT_W-1:0] remain_ff, remain_in;

   // Response register.
   logic                            rsp_valid_ff;
   bpa_pkg::status_type             status_ff;
   logic [bpa_pkg::GRANT_ID_W-1:0]  grant_ff;
   logic                            last_ff;
   logic [bpa_pkg::COUNT_OUT_W-1:0] free_ff;
   logic [bpa_pkg::COUNT_OUT_W-1:0] used_ff;

   logic            req_ready, accept, slot_free;
   logic            alloc_none, alloc_oom;
   logic            pop, push;
   logic            busy_we, busy_wbit, busy_re, busy_bit;
   logic [IDW-1:0]  busy_waddr;
   logic [IDW-1:0]  pop_id;
   logic [DW-1:0]   depth, low_mark;

   logic                           emit;
   bpa_pkg::status_type            emit_status;
   logic [bpa_pkg::GRANT_ID_W-1:0] emit_id;
   logic                           emit_last;
   logic [DW-1:0]                  emit_free;

   bpa_stack #(.POOL_SIZE(POOL_SIZE), .IDW(IDW), .DW(DW)) u_stack (
      .clock    (clock),
      .reset    (reset),
      .pop      (pop),
      .push     (push),
      .push_id  (id_ff),
      .depth    (depth),
      .low_mark (low_mark),
      .pop_id   (pop_id)
   );

   bpa_busy #(.POOL_SIZE(POOL_SIZE), .IDW(IDW), .DW(DW)) u_busy (
      .clock    (clock),
      .wr_en    (busy_we),
      .wr_addr  (busy_waddr),
      .wr_bit   (busy_wbit),
      .rd_en    (busy_re),
      .rd_addr  (req_port.blk_id[IDW-1:0]),
      .low_mark (low_mark),
      .busy     (busy_bit)
   );

   assign req_ready = (state_ff == bpa_pkg::ST_IDLE);
   assign accept    = req_port.valid && req_ready;
   // The response register can take a new response when it is empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp_port.ready;

   // Negative ids and ids past the pool are rejected; this check takes priority over the busy lookup.
   assign range_bad_in = req_port.blk_id[bpa_pkg::BLK_ID_W-1] ||
                         ($unsigned(req_port.blk_id) >= 16'(POOL_SIZE));

   assign alloc_none = (count_ff == '0);
   assign alloc_oom  = (count_ff > bpa_pkg::MAX_GRANT) ||
                       (CMPW'(count_ff) > CMPW'(depth));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_port.action == bpa_pkg::ACT_FREE) ?
                          bpa_pkg::ST_FREE_CHK : bpa_pkg::ST_ALLOC_CHK;
            end
         end
         bpa_pkg::ST_ALLOC_CHK: begin
            if (alloc_none || alloc_oom) begin
               if (slot_free) begin
                  state_in = bpa_pkg::ST_IDLE;
               end
            end else begin
               state_in = bpa_pkg::ST_ALLOC_RUN;
            end
         end
         bpa_pkg::ST_ALLOC_RUN: begin
            if (slot_free && remain_ff == bpa_pkg::COUNT_W'(1)) begin
               state_in = bpa_pkg::ST_IDLE;
            end
         end
         bpa_pkg::ST_FREE_CHK: begin
            if (slot_free) begin
               state_in = bpa_pkg::ST_IDLE;
            end
         end
         default: state_in = bpa_pkg::ST_IDLE;
      endcase
   end

   // Datapath control.
   always_comb begin
      pop         = 1'b0;
      push        = 1'b0;
      busy_we     = 1'b0;
      busy_wbit   = 1'b0;
      busy_waddr  = id_ff;
      busy_re     = accept && (req_port.action == bpa_pkg::ACT_FREE);
      remain_in   = remain_ff;
      emit        = 1'b0;
      emit_status = bpa_pkg::STATUS_OK;
      emit_id     = '0;
      emit_last   = 1'b1;
      emit_free   = depth;
      unique case (state_ff)
         bpa_pkg::ST_IDLE: begin
         end
         bpa_pkg::ST_ALLOC_CHK: begin
            if (alloc_none) begin
               emit        = slot_free;
               emit_status = bpa_pkg::STATUS_NONE;
            end else if (alloc_oom) begin
               emit        = slot_free;
               emit_status = bpa_pkg::STATUS_OOM;
            end else begin
               // Issue the first pop; its id shows up next cycle.
               pop       = 1'b1;
               remain_in = count_ff;
            end
         end
         bpa_pkg::ST_ALLOC_RUN: begin
            if (slot_free) begin
               emit       = 1'b1;
               emit_id    = bpa_pkg::GRANT_ID_W'(pop_id);
               emit_last  = (remain_ff == bpa_pkg::COUNT_W'(1));
               busy_we    = 1'b1;
               busy_wbit  = 1'b1;
               busy_waddr = pop_id;
               remain_in  = remain_ff - bpa_pkg::COUNT_W'(1);
               // Overlap the next pop with this response.
               pop        = (remain_ff != bpa_pkg::COUNT_W'(1));
            end
         end
         bpa_pkg::ST_FREE_CHK: begin
            if (slot_free) begin
               emit = 1'b1;
               if (range_bad_ff) begin
                  emit_status = bpa_pkg::STATUS_RANGE;
               end else if (!busy_bit) begin
                  emit_status = bpa_pkg::STATUS_DOUBLE;
               end else begin
                  busy_we = 1'b1;
                  push    = (depth != DW'(POOL_SIZE));
                  if (push) begin
                     emit_free = depth + DW'(1);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpa_pkg::ST_IDLE;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         remain_ff <= remain_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the request fields for the check cycle and register each emitted response.
   always_ff @(posedge clock) begin
      if (accept) begin
         count_ff     <= req_port.count;
         id_ff        <= req_port.blk_id[IDW-1:0];
         range_bad_ff <= range_bad_in;
      end
      if (emit) begin
         status_ff <= emit_status;
         grant_ff  <= emit_id;
         last_ff   <= emit_last;
         free_ff   <= bpa_pkg::COUNT_OUT_W'(emit_free);
         used_ff   <= bpa_pkg::COUNT_OUT_W'(DW'(POOL_SIZE) - emit_free);
      end
   end

   assign req_port.ready      = req_ready;
   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.status     = status_ff;
   assign rsp_port.granted_id = grant_ff;
   assign rsp_port.last       = last_ff;
   assign rsp_port.free_count = free_ff;
   assign rsp_port.used_count = used_ff;

endmodule
`default_nettype wire

// ===== hdl/bpa_checker.sv =====
`default_nettype none
module bpa_checker #(
   parameter int POOL_SIZE = 1024
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [bpa_pkg::STATUS_W-1:0]        status,
   input wire logic [bpa_pkg::GRANT_ID_W-1:0]      granted_id,
   input wire logic                                last,
   input wire logic [bpa_pkg::COUNT_OUT_W-1:0]     free_count,
   input wire logic [bpa_pkg::COUNT_OUT_W-1:0]     used_count
);

   // A stalled response stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
         $stable(granted_id) && $stable(last) && $stable(free_count))
      else $error("stalled response changed");

   // Every failure ends its request.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != bpa_pkg::STATUS_OK |-> last)
      else $error("error response without last");

   a_err_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != bpa_pkg::STATUS_OK |-> granted_id == '0)
      else $error("error response carries an id");

   a_counts_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> bpa_pkg::COUNT_OUT_W'(free_count + used_count) ==
                    bpa_pkg::COUNT_OUT_W'(POOL_SIZE))
      else $error("free and used counts do not add up");

endmodule

bind block_pool_allocator bpa_checker #(.POOL_SIZE(POOL_SIZE)) u_bpa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .status     (rsp_port.status),
   .granted_id (rsp_port.granted_id),
   .last       (rsp_port.last),
   .free_count (rsp_port.free_count),
   .used_count (rsp_port.used_count)
);
`default_nettype wire
